// ===== src/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared sizes, command codes and queue/RAM request types for the
// positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DEPTH       = 128;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CMD_W       = 2;
    localparam int POS_W       = 8;
    localparam int DATA_W      = 32;
    localparam int CNT_OUT_W   = 8;
    localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 48;
    localparam int S_PAD_W     = S_TDATA_W - CMD_W - POS_W - DATA_W;
    localparam int M_PAD_W     = M_TDATA_W - 1 - DATA_W - CNT_OUT_W - 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_INSERT,
        OP_DELETE
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [ADDR_W-1:0]   idx;
        logic [DATA_W-1:0]   value;
        logic                ok;
        logic [CNT_W-1:0]    cnt_before;
        logic [CNT_W-1:0]    cnt_after;
    } op_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [DATA_W-1:0]   wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } ram_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_WRVAL,
        ST_DONE
    } back_state_t;

endpackage

// ===== src/pal_ram.sv =====
// ----------------------------------------------------------------------------
// pal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pal_front.sv =====
// ----------------------------------------------------------------------------
// pal_front
// Accepts command beats, checks them against a shadow element count and
// queues a classified operation for the back end.
// ----------------------------------------------------------------------------
module pal_front
    import pal_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 q_full,
    output logic                 push,
    output op_t                  push_op,
    output logic [CNT_W-1:0]     shadow_count
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    cmd_t              cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [CMP_W-1:0]  pos_e;
    logic [CMP_W-1:0]  n_e;
    logic              in_range;
    logic              ins_range;

    always_comb begin
        cmd       = cmd_t'(s_axis_tdata[CMD_W-1:0]);
        pos       = s_axis_tdata[CMD_W +: POS_W];
        val       = s_axis_tdata[CMD_W + POS_W +: DATA_W];
        pos_e     = CMP_W'(pos);
        n_e       = CMP_W'(count_reg);
        in_range  = (pos != '0) && (pos_e <= n_e);
        ins_range = (pos != '0) && (pos_e <= n_e + CMP_W'(1))
                    && (count_reg < CNT_W'(DEPTH));

        push_op.kind       = OP_NONE;
        push_op.idx        = ADDR_W'(pos_e - CMP_W'(1));
        push_op.value      = val;
        push_op.ok         = 1'b0;
        push_op.cnt_before = count_reg;
        push_op.cnt_after  = count_reg;

        unique case (cmd)
            CMD_READ: begin
                if (in_range) begin
                    push_op.kind = OP_READ;
                    push_op.ok   = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (ins_range) begin
                    push_op.kind      = OP_INSERT;
                    push_op.ok        = 1'b1;
                    push_op.cnt_after = count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (in_range) begin
                    push_op.kind      = OP_DELETE;
                    push_op.ok        = 1'b1;
                    push_op.cnt_after = count_reg - CNT_W'(1);
                end
            end
            CMD_CLEAR: begin
                push_op.ok        = 1'b1;
                push_op.cnt_after = '0;
            end
        endcase
    end

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;
    assign count_next    = push ? push_op.cnt_after : count_reg;
    assign shadow_count  = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/pal_queue.sv =====
// ----------------------------------------------------------------------------
// pal_queue
// Short FIFO of classified operations between front and back end.
// ----------------------------------------------------------------------------
module pal_queue
    import pal_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output op_t  head_op
);

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
        return r;
    endfunction

    assign full       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== src/pal_back.sv =====
// ----------------------------------------------------------------------------
// pal_back
// Executes queued operations against the element RAM: reads, element
// shifts for insert and delete, and the result output register.
// ----------------------------------------------------------------------------
module pal_back
    import pal_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  op_t                  head_op,
    output logic                 pop,
    output ram_req_t             ram_req,
    input  logic [DATA_W-1:0]    ram_rdata,
    output logic                 back_idle,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    back_state_t            state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [ADDR_W-1:0]      src_reg, src_next;
    logic [CNT_W-1:0]       left_reg, left_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_cap_reg, pend_cap_next;
    logic [ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic [DATA_W-1:0]      data_reg, data_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic                   out_free;
    logic                   is_ins;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign is_ins    = (op_reg.kind == OP_INSERT);
    assign back_idle = (state_reg == ST_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    state_next = (head_op.kind == OP_NONE) ? ST_DONE : ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (left_reg == '0 && !pend_valid_reg) begin
                    state_next = is_ins ? ST_WRVAL : ST_DONE;
                end
            end
            ST_WRVAL: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next         = op_reg;
        src_next        = src_reg;
        left_next       = left_reg;
        pend_valid_next = pend_valid_reg;
        pend_cap_next   = pend_cap_reg;
        pend_addr_next  = pend_addr_reg;
        data_next       = data_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg;
        pop             = 1'b0;
        ram_req.we      = 1'b0;
        ram_req.waddr   = pend_addr_reg;
        ram_req.wdata   = ram_rdata;
        ram_req.re      = 1'b0;
        ram_req.raddr   = src_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    pop       = 1'b1;
                    op_next   = head_op;
                    data_next = '0;
                    left_next = '0;
                    unique case (head_op.kind)
                        OP_READ: begin
                            ram_req.re      = 1'b1;
                            ram_req.raddr   = head_op.idx;
                            pend_valid_next = 1'b1;
                            pend_cap_next   = 1'b1;
                        end
                        OP_DELETE: begin
                            // removed word first, then pull later words down
                            ram_req.re      = 1'b1;
                            ram_req.raddr   = head_op.idx;
                            pend_valid_next = 1'b1;
                            pend_cap_next   = 1'b1;
                            left_next       = head_op.cnt_before - CNT_W'(1)
                                              - CNT_W'(head_op.idx);
                            src_next        = head_op.idx + ADDR_W'(1);
                        end
                        OP_INSERT: begin
                            // move words from the top down to the insert slot
                            left_next = head_op.cnt_before - CNT_W'(head_op.idx);
                            src_next  = ADDR_W'(head_op.cnt_before - CNT_W'(1));
                        end
                        OP_NONE: begin
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                if (pend_valid_reg) begin
                    if (pend_cap_reg) begin
                        data_next = ram_rdata;
                    end else begin
                        ram_req.we = 1'b1;
                    end
                end
                if (left_reg != '0) begin
                    ram_req.re      = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_cap_next   = 1'b0;
                    pend_addr_next  = is_ins ? src_reg + ADDR_W'(1)
                                             : src_reg - ADDR_W'(1);
                    src_next        = is_ins ? src_reg - ADDR_W'(1)
                                             : src_reg + ADDR_W'(1);
                    left_next       = left_reg - CNT_W'(1);
                end else begin
                    pend_valid_next = 1'b0;
                end
            end
            ST_WRVAL: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = op_reg.idx;
                ram_req.wdata = op_reg.value;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {M_PAD_W'(0),
                                    (op_reg.cnt_after == '0),
                                    CNT_OUT_W'(op_reg.cnt_after),
                                    data_reg,
                                    op_reg.ok};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        src_reg       <= src_next;
        left_reg      <= left_next;
        pend_cap_reg  <= pend_cap_next;
        pend_addr_reg <= pend_addr_next;
        data_reg      <= data_next;
        m_data_reg    <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== src/positional_array_list_core.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_core
// Bounded ordered list of signed 32-bit words addressed by 1-based position.
// ----------------------------------------------------------------------------
// Each command beat gives one result beat. The front end checks a command
// against its own element count in the beat's cycle and queues it (two
// deep); the back end then runs it against a single-port-per-direction RAM,
// moving one stored word per cycle. Clear and refused commands go straight
// to the result, a read fetches one word, a delete reads the removed word
// and pulls later words down, and an insert moves the words from its slot
// up one place, then writes the value. The element shift through the one
// RAM read and one RAM write port sets the rate; results wait in an output
// register so the back end only stalls when a result is still unclaimed at
// the end of the next command. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module positional_array_list_core
    import pal_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [1:0] command, [9:2] position, [41:10] value, [47:42] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] ok, [32:1] data_out, [40:33] count, [41] is_empty, [47:42] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic              push;
    op_t               push_op;
    logic              q_full;
    logic              head_valid;
    op_t               head_op;
    logic              pop;
    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              back_idle;
    logic [CNT_W-1:0]  shadow_count;

    pal_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .push          (push),
        .push_op       (push_op),
        .shadow_count  (shadow_count)
    );

    pal_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_op    (push_op),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    pal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    pal_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_op       (head_op),
        .pop           (pop),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata),
        .back_idle     (back_idle),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // a refused command never returns a word
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[DATA_W:1] == '0))
        else $error("refused result carries nonzero data");

    // the RAM is only written while an operation is in progress
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.we |-> !back_idle)
        else $error("RAM write with back end idle");

    // front end never lets the list grow past its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        shadow_count <= CNT_W'(DEPTH))
        else $error("element count beyond capacity");

    // back end takes work from the queue only when it holds an entry
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (head_valid && back_idle))
        else $error("queue popped while empty or busy");

endmodule
